>>> design/hsl_pkg.sv
`timescale 1ns / 1ps

package hsl_pkg;

  // Internal unsigned fixed point: one unit is 2**FRAC_BITS.
  localparam int FRAC_BITS = 16;

  // A chroma, lightness, secondary or offset value reaches exactly one unit.
  localparam int CW    = FRAC_BITS + 1;
  localparam int SUM_W = FRAC_BITS + 2;

  localparam int PCT_W  = 7;
  localparam int PROD_W = 2 * PCT_W;
  localparam int WGT_W  = 6;

  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [PROD_W-1:0] PCT_SQ    = 14'd10000;
  localparam logic [WGT_W-1:0]  SIXTY     = 6'd60;
  localparam logic [7:0]        CHAN_MAX  = 8'd255;
  localparam logic [8:0]        HUE_PAIR  = 9'd120;

  // Guard bits of the reciprocal divisions; each makes the first quotient
  // at most one below the true floor.
  localparam int CHROMA_GUARD = PROD_W;
  localparam int LIGHT_GUARD  = PCT_W;
  localparam int SECOND_SHIFT = FRAC_BITS + WGT_W;

  localparam longint unsigned RECIP_CHROMA_L =
    (64'd1 << (FRAC_BITS + CHROMA_GUARD)) / 64'd10000;
  localparam longint unsigned RECIP_LIGHT_L =
    (64'd1 << (FRAC_BITS + LIGHT_GUARD)) / 64'd100;
  localparam longint unsigned RECIP_SIXTY_L =
    (64'd1 << SECOND_SHIFT) / 64'd60;

  localparam logic [CW-1:0] RECIP_CHROMA = CW'(RECIP_CHROMA_L);
  localparam logic [CW-1:0] RECIP_LIGHT  = CW'(RECIP_LIGHT_L);
  localparam logic [CW-1:0] RECIP_SIXTY  = CW'(RECIP_SIXTY_L);

  // Cycles from an accepted item to its result strobe.
  localparam int PIPE_LAT = 7;

  // 60-degree hue sectors, named by the colors at their two ends.
  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    logic              vld;
    logic [PROD_W-1:0] pct_prod;
    logic [PCT_W-1:0]  light;
    logic [WGT_W-1:0]  wgt;
    sector_t           sec;
    logic [7:0]        alpha;
  } front_t;

  typedef struct packed {
    logic          vld;
    logic [CW-1:0] chroma;
    logic [CW-1:0] lfix;
    logic [WGT_W-1:0] wgt;
    sector_t       sec;
    logic [7:0]    alpha;
  } base_t;

  typedef struct packed {
    logic          vld;
    logic [CW-1:0] chroma;
    logic [CW-1:0] second;
    logic [CW-1:0] offs;
    sector_t       sec;
    logic [7:0]    alpha;
  } comp_t;

endpackage

>>> design/hsl_front.sv
`timescale 1ns / 1ps

module hsl_front import hsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_go,
  input  logic [8:0]       hue,
  input  logic [PCT_W-1:0] sat,
  input  logic [PCT_W-1:0] light,
  input  logic [7:0]       alpha,
  output front_t           front_o
);

  logic [PCT_W-1:0] sat_c;
  logic [PCT_W-1:0] light_c;
  logic [PCT_W:0]   twol;
  logic [PCT_W-1:0] light_dev;
  logic [PCT_W-1:0] chroma_pct;
  logic [2:0]       pair;
  logic [8:0]       base;
  logic [6:0]       pos;
  logic             upper;
  logic [WGT_W-1:0] pdist;
  logic [3:0]       raw_sec;
  sector_t          sec;
  front_t           front_nxt;
  front_t           front_r;

  always_comb begin
    sat_c   = (sat > PCT_FULL) ? PCT_FULL : sat;
    light_c = (light > PCT_FULL) ? PCT_FULL : light;
    twol    = {light_c, 1'b0};
    if (twol >= {1'b0, PCT_FULL}) begin
      light_dev = PCT_W'(twol - {1'b0, PCT_FULL});
    end else begin
      light_dev = PCT_W'({1'b0, PCT_FULL} - twol);
    end
    chroma_pct = PCT_FULL - light_dev;
  end

  // Hue is split into 120-degree pairs of sectors; pos is the place in the pair.
  always_comb begin
    if (hue >= 9'(4 * HUE_PAIR)) begin
      pair = 3'd4;
    end else if (hue >= 9'(3 * HUE_PAIR)) begin
      pair = 3'd3;
    end else if (hue >= 9'(2 * HUE_PAIR)) begin
      pair = 3'd2;
    end else if (hue >= HUE_PAIR) begin
      pair = 3'd1;
    end else begin
      pair = 3'd0;
    end
    base  = 9'(pair) * HUE_PAIR;
    pos   = 7'(hue - base);
    upper = (pos >= 7'(SIXTY));
    if (upper) begin
      pdist = WGT_W'(pos - 7'(SIXTY));
    end else begin
      pdist = WGT_W'(7'(SIXTY) - pos);
    end
    raw_sec = {pair, upper};
    case (raw_sec)
      4'd0:    sec = SEC_RED_YEL;
      4'd1:    sec = SEC_YEL_GRN;
      4'd2:    sec = SEC_GRN_CYN;
      4'd3:    sec = SEC_CYN_BLU;
      4'd4:    sec = SEC_BLU_MAG;
      default: sec = SEC_MAG_RED;
    endcase
  end

  always_comb begin
    front_nxt.vld      = in_go;
    front_nxt.pct_prod = PROD_W'(chroma_pct) * PROD_W'(sat_c);
    front_nxt.light    = light_c;
    front_nxt.wgt      = SIXTY - pdist;
    front_nxt.sec      = sec;
    front_nxt.alpha    = alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign front_o = front_r;

endmodule

>>> design/hsl_cdiv.sv
`timescale 1ns / 1ps

module hsl_cdiv import hsl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  front_t front_i,
  output base_t  base_o
);

  localparam int CP_W = PROD_W + CW;
  localparam int LP_W = PCT_W + CW;
  localparam int CR_W = PROD_W + FRAC_BITS;
  localparam int LR_W = PCT_W + FRAC_BITS;

  logic [CP_W-1:0]   cprod;
  logic [LP_W-1:0]   lprod;
  logic              vld_r;
  logic [CW-1:0]     qc_r;
  logic [CW-1:0]     ql_r;
  logic [PROD_W-1:0] pct_prod_r;
  logic [PCT_W-1:0]  light_r;
  logic [WGT_W-1:0]  wgt_r;
  sector_t           sec_r;
  logic [7:0]        alpha_r;
  logic [CR_W-1:0]   crem;
  logic [LR_W-1:0]   lrem;
  base_t             base_nxt;
  base_t             base_r;

  // First stage: quotient estimates by reciprocal multiplication.
  always_comb begin
    cprod = CP_W'(front_i.pct_prod) * CP_W'(RECIP_CHROMA);
    lprod = LP_W'(front_i.light) * LP_W'(RECIP_LIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= front_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    qc_r       <= cprod[CHROMA_GUARD +: CW];
    ql_r       <= lprod[LIGHT_GUARD +: CW];
    pct_prod_r <= front_i.pct_prod;
    light_r    <= front_i.light;
    wgt_r      <= front_i.wgt;
    sec_r      <= front_i.sec;
    alpha_r    <= front_i.alpha;
  end

  // Second stage: a remainder of a full divisor or more bumps the quotient.
  always_comb begin
    crem = CR_W'({pct_prod_r, {FRAC_BITS{1'b0}}}) - CR_W'(qc_r) * CR_W'(PCT_SQ);
    lrem = LR_W'({light_r, {FRAC_BITS{1'b0}}}) - LR_W'(ql_r) * LR_W'(PCT_FULL);
    base_nxt.vld    = vld_r;
    base_nxt.chroma = (crem >= CR_W'(PCT_SQ)) ? qc_r + CW'(1) : qc_r;
    base_nxt.lfix   = (lrem >= LR_W'(PCT_FULL)) ? ql_r + CW'(1) : ql_r;
    base_nxt.wgt    = wgt_r;
    base_nxt.sec    = sec_r;
    base_nxt.alpha  = alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  assign base_o = base_r;

endmodule

>>> design/hsl_xdiv.sv
`timescale 1ns / 1ps

module hsl_xdiv import hsl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  base_t base_i,
  output comp_t comp_o
);

  localparam int N_W = CW + WGT_W;
  localparam int P_W = N_W + CW;

  logic [N_W-1:0] num;
  logic [CW-1:0]  half;
  logic [CW-1:0]  offs;
  logic           vld_a_r;
  logic [N_W-1:0] num_a_r;
  logic [CW-1:0]  chroma_a_r;
  logic [CW-1:0]  offs_a_r;
  sector_t        sec_a_r;
  logic [7:0]     alpha_a_r;
  logic [P_W-1:0] qprod;
  logic           vld_b_r;
  logic [CW-1:0]  q_b_r;
  logic [N_W-1:0] num_b_r;
  logic [CW-1:0]  chroma_b_r;
  logic [CW-1:0]  offs_b_r;
  sector_t        sec_b_r;
  logic [7:0]     alpha_b_r;
  logic [N_W-1:0] rem;
  comp_t          comp_nxt;
  comp_t          comp_r;

  // Stage A: weighted chroma and the lightness offset, floored at zero.
  always_comb begin
    num  = N_W'(base_i.chroma) * N_W'(base_i.wgt);
    half = base_i.chroma >> 1;
    offs = (base_i.lfix >= half) ? base_i.lfix - half : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= base_i.vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    num_a_r    <= num;
    chroma_a_r <= base_i.chroma;
    offs_a_r   <= offs;
    sec_a_r    <= base_i.sec;
    alpha_a_r  <= base_i.alpha;
  end

  // Stage B: quotient estimate of the division by sixty.
  assign qprod = P_W'(num_a_r) * P_W'(RECIP_SIXTY);

  always_ff @(posedge clk) begin
    q_b_r      <= qprod[SECOND_SHIFT +: CW];
    num_b_r    <= num_a_r;
    chroma_b_r <= chroma_a_r;
    offs_b_r   <= offs_a_r;
    sec_b_r    <= sec_a_r;
    alpha_b_r  <= alpha_a_r;
  end

  // Stage C: remainder check and correction.
  always_comb begin
    rem = num_b_r - N_W'(q_b_r) * N_W'(SIXTY);
    comp_nxt.vld    = vld_b_r;
    comp_nxt.chroma = chroma_b_r;
    comp_nxt.second = (rem >= N_W'(SIXTY)) ? q_b_r + CW'(1) : q_b_r;
    comp_nxt.offs   = offs_b_r;
    comp_nxt.sec    = sec_b_r;
    comp_nxt.alpha  = alpha_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r <= '0;
    end else begin
      comp_r <= comp_nxt;
    end
  end

  assign comp_o = comp_r;

endmodule

>>> design/hsl_out.sv
`timescale 1ns / 1ps

module hsl_out import hsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  comp_t       comp_i,
  output logic        out_valid,
  output logic [31:0] out_rgba_word
);

  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;
  logic          valid_r;
  logic [31:0]   rgba_r;
  logic [31:0]   rgba_nxt;

  // (comp + offs) * 255, scaled down by one unit and clamped to a byte.
  function automatic logic [7:0] scale_chan(input logic [CW-1:0] comp,
                                            input logic [CW-1:0] offs);
    logic [SUM_W-1:0]   sum;
    logic [SUM_W+7:0]   wide;
    logic [SUM_W+7-FRAC_BITS:0] lvl;
    sum  = SUM_W'(comp) + SUM_W'(offs);
    wide = {sum, 8'd0} - (SUM_W+8)'(sum);
    lvl  = wide[SUM_W+7:FRAC_BITS];
    if (lvl > (SUM_W+8-FRAC_BITS)'(CHAN_MAX)) begin
      return CHAN_MAX;
    end
    return lvl[7:0];
  endfunction

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    case (comp_i.sec)
      SEC_RED_YEL: begin
        red   = comp_i.chroma;
        green = comp_i.second;
      end
      SEC_YEL_GRN: begin
        red   = comp_i.second;
        green = comp_i.chroma;
      end
      SEC_GRN_CYN: begin
        green = comp_i.chroma;
        blue  = comp_i.second;
      end
      SEC_CYN_BLU: begin
        green = comp_i.second;
        blue  = comp_i.chroma;
      end
      SEC_BLU_MAG: begin
        red   = comp_i.second;
        blue  = comp_i.chroma;
      end
      default: begin
        red   = comp_i.chroma;
        blue  = comp_i.second;
      end
    endcase
    rgba_nxt = {scale_chan(red, comp_i.offs), scale_chan(green, comp_i.offs),
                scale_chan(blue, comp_i.offs), comp_i.alpha};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= comp_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    rgba_r <= rgba_nxt;
  end

  assign out_valid     = valid_r;
  assign out_rgba_word = rgba_r;

endmodule

>>> design/hsl_to_rgb_converter.sv
// HSL to packed RGBA converter, seven register stages.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Reset (rst_n low, synchronous) clears every stage valid bit; items in flight
// are dropped. Results are shown for one cycle and cannot be held off.
`timescale 1ns / 1ps

module hsl_to_rgb_converter import hsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [8:0]       in_hue_degrees,
  input  logic [PCT_W-1:0] in_saturation_pct,
  input  logic [PCT_W-1:0] in_lightness_pct,
  input  logic [7:0]       in_alpha_code,
  output logic             out_valid,
  output logic [31:0]      out_rgba_word
);

  // The pipeline never stalls: the receiver takes every result strobe, so
  // there is nothing that could back up into the input side.
  front_t front;
  base_t  base;
  comp_t  comp;

  assign busy = 1'b0;

  // Stage 1: clamp the percents, form (100 - |2l - 100|) * s, split the hue
  // into its sector and the weight of the secondary component.
  hsl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_go   (start),
    .hue     (in_hue_degrees),
    .sat     (in_saturation_pct),
    .light   (in_lightness_pct),
    .alpha   (in_alpha_code),
    .front_o (front)
  );

  // Stages 2 and 3: chroma = prod / 10000 and lightness = l / 100 in fixed
  // point, each as a reciprocal multiply followed by a one-step correction.
  hsl_cdiv u_cdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .front_i (front),
    .base_o  (base)
  );

  // Stages 4 to 6: the secondary component chroma * weight / 60, and the
  // lightness offset L - chroma / 2 floored at zero.
  hsl_xdiv u_xdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .base_i (base),
    .comp_o (comp)
  );

  // Stage 7: place the components by sector, add the offset, scale each
  // channel to a byte and pack the word with alpha in the low byte.
  hsl_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .comp_i        (comp),
    .out_valid     (out_valid),
    .out_rgba_word (out_rgba_word)
  );

endmodule

>>> design/hsl_chk.sv
`timescale 1ns / 1ps

module hsl_chk import hsl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [PCT_W-1:0] in_saturation_pct,
  input logic [PCT_W-1:0] in_lightness_pct,
  input logic [7:0]       in_alpha_code,
  input logic             out_valid,
  input logic [31:0]      out_rgba_word
);

  // Every accepted item yields a strobe a fixed latency later.
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted item produced no result strobe");

  // No strobe without an item accepted a fixed latency earlier.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, PIPE_LAT) && !$past(busy, PIPE_LAT)))
    else $error("result strobe without an accepted item");

  // Alpha travels with its item unchanged.
  a_alpha_carried: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rgba_word[7:0] == $past(in_alpha_code, PIPE_LAT)))
    else $error("alpha byte does not match its item");

  // Zero saturation gives a gray: all three channels equal.
  a_gray_at_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_saturation_pct == '0) |-> ##PIPE_LAT
      (out_rgba_word[31:24] == out_rgba_word[23:16] &&
       out_rgba_word[23:16] == out_rgba_word[15:8]))
    else $error("zero saturation did not give a gray");

  // Zero lightness gives black.
  a_black_at_zero_light: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_lightness_pct == '0) |-> ##PIPE_LAT
      (out_rgba_word[31:8] == 24'd0))
    else $error("zero lightness did not give black");

endmodule

bind hsl_to_rgb_converter hsl_chk u_hsl_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_saturation_pct (in_saturation_pct),
  .in_lightness_pct  (in_lightness_pct),
  .in_alpha_code     (in_alpha_code),
  .out_valid         (out_valid),
  .out_rgba_word     (out_rgba_word)
);

>>> bench/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;
  import hsl_pkg::*;

  // Number of random items that follow the directed ones.
  localparam int RANDOM_ITEMS = 1050;
  // Random items in this window are sent back to back, with start held high.
  localparam int BURST_FIRST = 400;
  localparam int BURST_LAST  = 649;
  // Chance, in percent, that the sender idles on a given cycle.
  localparam int IDLE_PCT = 19;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [8:0]       in_hue_degrees;
  logic [PCT_W-1:0] in_saturation_pct;
  logic [PCT_W-1:0] in_lightness_pct;
  logic [7:0]       in_alpha_code;
  logic             out_valid;
  logic [31:0]      out_rgba_word;

  hsl_to_rgb_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_hue_degrees    (in_hue_degrees),
    .in_saturation_pct (in_saturation_pct),
    .in_lightness_pct  (in_lightness_pct),
    .in_alpha_code     (in_alpha_code),
    .out_valid         (out_valid),
    .out_rgba_word     (out_rgba_word)
  );

  // The scoreboard keeps the RGBA words that accepted items should produce,
  // oldest first. The block has no state, so each word depends on its own
  // item alone and the words come back in the order the items went in.
  class rgba_scoreboard;
    logic [31:0] expected_rgba[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Scales one component plus the lightness offset to a byte, truncating,
    // and clamps anything above full scale.
    function automatic logic [7:0] scale_to_byte(longint unsigned comp,
                                                 longint unsigned offs);
      longint unsigned scaled;
      scaled = ((comp + offs) * 64'd255) >> FRAC_BITS;
      return (scaled > 64'd255) ? CHAN_MAX : scaled[7:0];
    endfunction

    // Converts one HSL pixel to the packed word, all in unsigned fixed point
    // with FRAC_BITS fraction bits and floor at every division.
    function automatic logic [31:0] rgba_from_hsl(logic [8:0] hue,
                                                  logic [PCT_W-1:0] sat_raw,
                                                  logic [PCT_W-1:0] light_raw,
                                                  logic [7:0] alpha);
      longint unsigned unit, sat, light, twice_light, light_dev, chroma;
      longint unsigned pos, pos_dist, second, light_fix, half_chroma, offs;
      longint unsigned red, grn, blu;
      int unsigned sector;
      unit  = 64'd1 << FRAC_BITS;
      // Percents above 100 saturate.
      sat   = (sat_raw > PCT_FULL) ? 64'd100 : 64'(sat_raw);
      light = (light_raw > PCT_FULL) ? 64'd100 : 64'(light_raw);

      twice_light = 64'd2 * light;
      light_dev = (twice_light >= 64'd100) ? twice_light - 64'd100
                                           : 64'd100 - twice_light;
      chroma = ((64'd100 - light_dev) * sat * unit) / 64'd10000;

      // The secondary component rises and falls over each 120-degree pair.
      pos      = 64'(hue) % 64'd120;
      pos_dist = (pos >= 64'd60) ? pos - 64'd60 : 64'd60 - pos;
      second   = (chroma * (64'd60 - pos_dist)) / 64'd60;

      light_fix   = (light * unit) / 64'd100;
      half_chroma = chroma >> 1;
      offs = (light_fix >= half_chroma) ? light_fix - half_chroma : 64'd0;

      red = 0;
      grn = 0;
      blu = 0;
      // Hue 360 and above lands past the last sector and takes its layout.
      sector = hue / 9'd60;
      case (sector)
        SEC_RED_YEL: begin red = chroma; grn = second; end
        SEC_YEL_GRN: begin red = second; grn = chroma; end
        SEC_GRN_CYN: begin grn = chroma; blu = second; end
        SEC_CYN_BLU: begin grn = second; blu = chroma; end
        SEC_BLU_MAG: begin red = second; blu = chroma; end
        default:     begin red = chroma; blu = second; end
      endcase

      return {scale_to_byte(red, offs), scale_to_byte(grn, offs),
              scale_to_byte(blu, offs), alpha};
    endfunction

    function void note_item(logic [8:0] hue, logic [PCT_W-1:0] sat,
                            logic [PCT_W-1:0] light, logic [7:0] alpha);
      expected_rgba.push_back(rgba_from_hsl(hue, sat, light, alpha));
    endfunction

    function void check_word(logic [31:0] actual);
      logic [31:0] expected;
      if (expected_rgba.size() == 0) begin
        $display("%0t: unexpected rgba_word result, expected none, got %08h",
                 $time, actual);
        mismatches++;
      end else begin
        expected = expected_rgba.pop_front();
        if (actual !== expected) begin
          $display("%0t: rgba_word mismatch, expected %08h, got %08h",
                   $time, expected, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  rgba_scoreboard board = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are judged on the values seen just before the edge, so
  // the bench and the block agree on which cycles move an item or a result.
  // An item accepted now cannot have its result at the same edge, so the order of
  // the two calls at one edge does not matter.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      board.note_item(in_hue_degrees, in_saturation_pct, in_lightness_pct,
                      in_alpha_code);
    if (rst_n && out_valid)
      board.check_word(out_rgba_word);
  end

  // Offers one item and returns at the edge that accepts it. When idling is
  // allowed, the sender drops start for a random number of cycles first;
  // otherwise start simply stays high from the previous item.
  task automatic send_item(input logic [8:0] hue, input logic [PCT_W-1:0] sat,
                           input logic [PCT_W-1:0] light, input logic [7:0] alpha,
                           input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start             <= 1'b1;
    in_hue_degrees    <= hue;
    in_saturation_pct <= sat;
    in_lightness_pct  <= light;
    in_alpha_code     <= alpha;
    do @(posedge clk); while (busy);
  endtask

  // Picks a percent: mostly in range, some exactly at the ends, and a share
  // above 100 to exercise saturation.
  function automatic logic [PCT_W-1:0] pick_pct();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10)
      return (roll < 5) ? 7'd0 : PCT_FULL;
    else if (roll < 75)
      return PCT_W'($urandom_range(100));
    else
      return PCT_W'($urandom_range(127));
  endfunction

  initial begin
    logic [8:0] hue;
    int drain_cycles;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_hue_degrees    <= '0;
    in_saturation_pct <= '0;
    in_lightness_pct  <= '0;
    in_alpha_code     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items. Fully saturated mid-lightness colors walk an edge of every
    // sector and both edges of most, then come gray, black and white, the clamping
    // of percents above 100, small and odd values, and hues past 359.
    send_item(9'd0,   7'd100, 7'd50,  8'h00, 1'b1);
    send_item(9'd59,  7'd100, 7'd50,  8'hFF, 1'b1);
    send_item(9'd60,  7'd100, 7'd50,  8'h5A, 1'b1);
    send_item(9'd119, 7'd100, 7'd50,  8'hA5, 1'b1);
    send_item(9'd120, 7'd100, 7'd50,  8'h01, 1'b1);
    send_item(9'd180, 7'd100, 7'd50,  8'h80, 1'b1);
    send_item(9'd239, 7'd100, 7'd50,  8'h7F, 1'b1);
    send_item(9'd240, 7'd100, 7'd50,  8'hFE, 1'b1);
    send_item(9'd300, 7'd100, 7'd50,  8'h33, 1'b1);
    send_item(9'd359, 7'd100, 7'd50,  8'hCC, 1'b1);
    send_item(9'd30,  7'd0,   7'd50,  8'h10, 1'b1);
    send_item(9'd90,  7'd100, 7'd0,   8'h20, 1'b1);
    send_item(9'd150, 7'd100, 7'd100, 8'h40, 1'b1);
    send_item(9'd210, 7'd127, 7'd127, 8'hFF, 1'b1);
    send_item(9'd270, 7'd101, 7'd75,  8'h00, 1'b1);
    send_item(9'd330, 7'd63,  7'd25,  8'h55, 1'b1);
    send_item(9'd360, 7'd100, 7'd50,  8'hAA, 1'b1);
    send_item(9'd420, 7'd80,  7'd40,  8'h0F, 1'b1);
    send_item(9'd511, 7'd127, 7'd64,  8'hF0, 1'b1);
    send_item(9'd45,  7'd1,   7'd1,   8'h3C, 1'b1);
    send_item(9'd15,  7'd100, 7'd99,  8'hC3, 1'b1);

    // Random items. Most hues stay in 0..359; the rest use the whole 9-bit
    // field so the top bit and the wrap past the last sector get exercised.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(99) < 85)
        hue = 9'($urandom_range(359));
      else
        hue = 9'($urandom_range(511));
      send_item(hue, pick_pct(), pick_pct(), 8'($urandom_range(255)),
                !(i >= BURST_FIRST && i <= BURST_LAST));
    end
    start <= 1'b0;

    // Let every outstanding result come back, then a few more cycles to
    // catch any stray strobe.
    drain_cycles = 0;
    while (board.expected_rgba.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);

    if (board.expected_rgba.size() != 0) begin
      $display("%0t: rgba_word results missing, expected %0d more, got none",
               $time, board.expected_rgba.size());
      board.mismatches++;
    end

    if (board.mismatches == 0)
      $display("hsl_to_rgb_converter verification clean");
    else
      $display("hsl_to_rgb_converter verification failed");
    $finish;
  end

  // Watchdog: a run that hangs is stopped and reported as failed.
  initial begin
    #2_000_000;
    $display("hsl_to_rgb_converter verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/hsl_pkg.sv
design/hsl_front.sv
design/hsl_cdiv.sv
design/hsl_xdiv.sv
design/hsl_out.sv
design/hsl_to_rgb_converter.sv
design/hsl_chk.sv
bench/hsl_to_rgb_converter_tb.sv
